[hdl/ucrh_pkg.sv]
// ----------------------------------------------------------------------------
// ucrh_pkg
// Shared types and codes for the USB control request handler: event and
// response codes, standard request codes, and the word and result structs.
// ----------------------------------------------------------------------------
package ucrh_pkg;

  // largest setup packet the control endpoint takes
  localparam logic [6:0] CTRL_PACKET_BYTES = 7'd64;
  // a setup packet shorter than this many bytes is stalled
  localparam logic [6:0] SETUP_BYTES       = 7'd8;

  // configuration register indexes
  localparam logic [1:0] REG_DEVICE_DESC_LEN = 2'd0;
  localparam logic [1:0] REG_CONFIG_DESC_LEN = 2'd1;
  localparam logic [1:0] REG_CONFIG_COUNT    = 2'd2;
  localparam logic [1:0] REG_INTERFACE_COUNT = 2'd3;

  typedef enum logic [1:0] {
    OP_SETUP     = 2'd0,
    OP_BUS_RESET = 2'd1,
    OP_OUT_DONE  = 2'd2,
    OP_IN_DONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DEFAULT    = 2'd0,
    ST_ADDRESSED  = 2'd1,
    ST_CONFIGURED = 2'd2
  } dev_state_t;

  typedef enum logic [2:0] {
    RSP_NONE    = 3'd0,
    RSP_STALL   = 3'd1,
    RSP_STATUS  = 3'd2,
    RSP_DATA    = 3'd3,
    RSP_RXSTART = 3'd4
  } resp_t;

  // recipient field of bmRequestType
  localparam logic [4:0] RCPT_DEVICE    = 5'd0;
  localparam logic [4:0] RCPT_INTERFACE = 5'd1;
  localparam logic [4:0] RCPT_ENDPOINT  = 5'd2;

  // type field of bmRequestType
  localparam logic [1:0] TYPE_CLASS = 2'd1;

  // standard request codes
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

  // descriptor types
  localparam logic [7:0] DESC_DEVICE      = 8'd1;
  localparam logic [7:0] DESC_CONFIG      = 8'd2;
  localparam logic [7:0] DESC_STRING      = 8'd3;
  localparam logic [7:0] DESC_QUALIFIER   = 8'd6;
  localparam logic [7:0] DESC_OTHER_SPEED = 8'd7;

  // endpoint 0 IN address and the status reply length
  localparam logic [7:0]  EP0_IN_ADDR    = 8'h80;
  localparam logic [15:0] STATUS_REPLY_LEN = 16'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  endpoint_number;
    logic [6:0]  packet_size;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
    logic [7:0]  string_length;
    logic        class_init_ok;
    logic        class_setup_ok;
  } item_t;

  typedef struct packed {
    resp_t       response;
    logic [15:0] transmit_length;
    logic        address_load;
    logic [6:0]  new_address;
    logic        class_init_request;
    logic        class_deinit_request;
    logic [7:0]  released_config;
    logic        class_forward;
    logic        halt_clear;
    dev_state_t  device_state;
    logic [7:0]  selected_config;
  } result_t;

  typedef struct packed {
    logic [7:0]  device_desc_len;
    logic [15:0] config_desc_len;
    logic [7:0]  config_count;
    logic [7:0]  interface_count;
  } cfg_t;

endpackage

[hdl/ucrh_decode.sv]
// ----------------------------------------------------------------------------
// ucrh_decode
// Decodes one control endpoint word against the device state and the
// configuration registers; gives the result and the next device state.
// ----------------------------------------------------------------------------
module ucrh_decode #(
  parameter logic [6:0] CONTROL_PACKET_BYTES = ucrh_pkg::CTRL_PACKET_BYTES
) (
  input  ucrh_pkg::item_t      item,
  input  ucrh_pkg::cfg_t       cfg,
  input  ucrh_pkg::dev_state_t state,
  input  logic [7:0]           config_cur,
  output ucrh_pkg::result_t    res,
  output ucrh_pkg::dev_state_t state_next,
  output logic [7:0]           config_next
);
  import ucrh_pkg::*;

  logic        ep0;
  logic        setup_bad;
  logic [7:0]  desc_kind;
  logic [15:0] desc_len;
  logic [7:0]  cfg_idx;
  logic [7:0]  ep_addr;
  logic        feat_halt;

  assign ep0       = (item.endpoint_number == 4'd0);
  assign setup_bad = !ep0 || (item.packet_size < SETUP_BYTES) ||
                     (item.packet_size > CONTROL_PACKET_BYTES);
  assign desc_kind = item.request_value[15:8];
  assign cfg_idx   = item.request_value[7:0];
  assign ep_addr   = item.request_index[7:0];
  assign feat_halt = (item.request_value == 16'd0);

  // pick the descriptor length by type
  always_comb begin
    case (desc_kind)
      DESC_DEVICE: desc_len = {8'd0, cfg.device_desc_len};
      DESC_CONFIG: desc_len = cfg.config_desc_len;
      DESC_STRING: desc_len = {8'd0, item.string_length};
      default:     desc_len = 16'd0;
    endcase
  end

  // decode the word
  always_comb begin
    res                 = '0;
    res.response        = RSP_NONE;
    state_next          = state;
    config_next         = config_cur;
    case (opcode_t'(item.opcode))
      OP_SETUP: begin
        if (setup_bad) begin
          res.response = RSP_STALL;
        end else begin
          case (item.request_type[4:0])
            RCPT_DEVICE: begin
              case (item.request_code)
                REQ_GET_DESCRIPTOR: begin
                  // stall an absent string or an unknown type
                  if (!(desc_kind inside {DESC_DEVICE, DESC_CONFIG, DESC_STRING,
                                          DESC_QUALIFIER, DESC_OTHER_SPEED}) ||
                      (desc_kind == DESC_STRING && item.string_length == 8'd0)) begin
                    res.response = RSP_STALL;
                  end
                  // clip the length to wLength
                  if (desc_len != 16'd0 && item.request_length != 16'd0) begin
                    res.response        = RSP_DATA;
                    res.transmit_length = (desc_len < item.request_length) ?
                                          desc_len : item.request_length;
                  end
                end
                REQ_SET_ADDRESS: begin
                  if (item.request_index != 16'd0 || item.request_length != 16'd0 ||
                      state == ST_CONFIGURED) begin
                    res.response = RSP_STALL;
                  end else begin
                    config_next      = 8'd0;
                    res.address_load = 1'b1;
                    res.new_address  = item.request_value[6:0];
                    res.response     = RSP_STATUS;
                    state_next       = (item.request_value[6:0] != 7'd0) ?
                                       ST_ADDRESSED : ST_DEFAULT;
                  end
                end
                REQ_SET_CONFIGURATION: begin
                  if (cfg_idx > cfg.config_count) begin
                    res.response = RSP_STALL;
                  end else if (state == ST_ADDRESSED) begin
                    res.response = RSP_STATUS;
                    if (cfg_idx != 8'd0) begin
                      config_next            = cfg_idx;
                      state_next             = ST_CONFIGURED;
                      res.class_init_request = 1'b1;
                      if (!item.class_init_ok) res.response = RSP_STALL;
                    end
                  end else if (state == ST_CONFIGURED) begin
                    res.response = RSP_STATUS;
                    if (cfg_idx == 8'd0) begin
                      res.class_deinit_request = 1'b1;
                      res.released_config      = config_cur;
                      config_next              = 8'd0;
                      state_next               = ST_ADDRESSED;
                    end else if (cfg_idx != config_cur) begin
                      // release the old configuration, keep the new one even if refused
                      res.class_deinit_request = 1'b1;
                      res.released_config      = config_cur;
                      config_next              = cfg_idx;
                      res.class_init_request   = 1'b1;
                      if (!item.class_init_ok) res.response = RSP_STALL;
                    end
                  end else begin
                    res.response = RSP_STALL;
                  end
                end
                REQ_GET_CONFIGURATION, REQ_CLEAR_FEATURE: begin
                  res.response = RSP_NONE;
                end
                REQ_SET_FEATURE: begin
                  res.response = RSP_STATUS;
                end
                REQ_GET_STATUS: begin
                  if (state == ST_ADDRESSED || state == ST_CONFIGURED) begin
                    res.response        = RSP_DATA;
                    res.transmit_length = STATUS_REPLY_LEN;
                  end else begin
                    res.response = RSP_STALL;
                  end
                end
                default: res.response = RSP_STALL;
              endcase
            end
            RCPT_INTERFACE: begin
              // hand the request to the class driver when the device is configured and the interface exists
              if (state == ST_CONFIGURED && item.request_index[7:0] < cfg.interface_count) begin
                res.class_forward = 1'b1;
                if (!item.class_setup_ok) res.response = RSP_STALL;
              end else begin
                res.response = RSP_STALL;
              end
            end
            RCPT_ENDPOINT: begin
              if (item.request_type[6:5] == TYPE_CLASS) begin
                res.class_forward = 1'b1;
              end else if (item.request_code == REQ_SET_FEATURE) begin
                if (state == ST_ADDRESSED) begin
                  if (ep_addr != 8'd0 && ep_addr != EP0_IN_ADDR) res.response = RSP_STALL;
                end else if (state == ST_CONFIGURED) begin
                  if (feat_halt && ep_addr != 8'd0 && ep_addr != EP0_IN_ADDR) begin
                    res.response = RSP_STALL;
                  end else begin
                    res.class_forward = 1'b1;
                  end
                end else begin
                  res.response = RSP_STALL;
                end
              end else if (item.request_code == REQ_CLEAR_FEATURE ||
                           item.request_code == REQ_GET_STATUS) begin
                if (state == ST_ADDRESSED) begin
                  if (ep_addr[6:0] != 7'd0) res.response = RSP_STALL;
                end else if (state == ST_CONFIGURED) begin
                  if (feat_halt && ep_addr[6:0] != 7'd0) begin
                    res.halt_clear    = 1'b1;
                    res.class_forward = 1'b1;
                  end
                end else begin
                  res.response = RSP_STALL;
                end
              end
            end
            default: res.response = RSP_STALL;
          endcase
        end
      end
      OP_BUS_RESET: begin
        // drop to default, keep the configuration index
        state_next = ST_DEFAULT;
      end
      OP_OUT_DONE: begin
        if (ep0) res.response = RSP_STATUS;
      end
      OP_IN_DONE: begin
        if (ep0) res.response = RSP_RXSTART;
      end
      default: res.response = RSP_NONE;
    endcase
    res.device_state    = state_next;
    res.selected_config = config_next;
  end

endmodule

[hdl/usb_control_request_handler.sv]
// ----------------------------------------------------------------------------
// usb_control_request_handler
// Standard control request handler for endpoint 0: tracks device state and
// the selected configuration and answers each endpoint event with one action.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event word: a setup packet,
//   a bus reset, an OUT-done or an IN-done. Output channel (out_valid/
//   out_ready) carries one result word per event: the endpoint action, the
//   transmit length, and the address, class and halt strobes, plus the
//   device state and configuration after the event.
//   The accepting edge loads the input register; the result register is then
//   loaded from one decode pass once it is free, and out_valid rises with it.
//   An event is taken every cycle while the receiver does not stall; the
//   rate is set by the single decode pass, which reads and updates the
//   state registers in the same cycle.
//   When the receiver stalls, the result register holds and one more word
//   waits in the input register; in_ready drops only when both are full.
//   Reset returns to the default state with configuration 0 and loads the
//   register reset values (device descriptor 18 bytes, config set 0 bytes,
//   one configuration, one interface). The user must write the registers on
//   cfg_write only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module usb_control_request_handler #(
  parameter logic [6:0] CONTROL_PACKET_BYTES = ucrh_pkg::CTRL_PACKET_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // event channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [3:0]  endpoint_number,
  input  logic [6:0]  packet_size,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_value,
  input  logic [15:0] request_index,
  input  logic [15:0] request_length,
  input  logic [7:0]  string_length,
  input  logic        class_init_ok,
  input  logic        class_setup_ok,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  response,
  output logic [15:0] transmit_length,
  output logic        address_load,
  output logic [6:0]  new_address,
  output logic        class_init_request,
  output logic        class_deinit_request,
  output logic [7:0]  released_config,
  output logic        class_forward,
  output logic        halt_clear,
  output logic [1:0]  device_state,
  output logic [7:0]  selected_config
);
  import ucrh_pkg::*;

  cfg_t       cfg;
  dev_state_t state;
  dev_state_t state_next;
  logic [7:0] config_cur;
  logic [7:0] config_next;

  item_t      in_word;
  item_t      s1_item;
  logic       s1_valid;
  result_t    res_next;
  result_t    res;
  logic       out_free;
  logic       advance;

  // hand-off between stages
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  assign in_word = '{
    opcode:          opcode,
    endpoint_number: endpoint_number,
    packet_size:     packet_size,
    request_type:    request_type,
    request_code:    request_code,
    request_value:   request_value,
    request_index:   request_index,
    request_length:  request_length,
    string_length:   string_length,
    class_init_ok:   class_init_ok,
    class_setup_ok:  class_setup_ok
  };

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_desc_len <= 8'd18;
      cfg.config_desc_len <= 16'd0;
      cfg.config_count    <= 8'd1;
      cfg.interface_count <= 8'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEVICE_DESC_LEN: cfg.device_desc_len <= cfg_data[7:0];
        REG_CONFIG_DESC_LEN: cfg.config_desc_len <= cfg_data;
        REG_CONFIG_COUNT:    cfg.config_count    <= cfg_data[7:0];
        REG_INTERFACE_COUNT: cfg.interface_count <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // hold the accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_word;
    end
  end

  ucrh_decode #(
    .CONTROL_PACKET_BYTES(CONTROL_PACKET_BYTES)
  ) u_decode (
    .item       (s1_item),
    .cfg        (cfg),
    .state      (state),
    .config_cur (config_cur),
    .res        (res_next),
    .state_next (state_next),
    .config_next(config_next)
  );

  // advance device state with each decoded word
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_DEFAULT;
      config_cur <= 8'd0;
    end else if (advance) begin
      state      <= state_next;
      config_cur <= config_next;
    end
  end

  // load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign response             = res.response;
  assign transmit_length      = res.transmit_length;
  assign address_load         = res.address_load;
  assign new_address          = res.new_address;
  assign class_init_request   = res.class_init_request;
  assign class_deinit_request = res.class_deinit_request;
  assign released_config      = res.released_config;
  assign class_forward        = res.class_forward;
  assign halt_clear           = res.halt_clear;
  assign device_state         = res.device_state;
  assign selected_config      = res.selected_config;

endmodule
